[rtl/vote_lockout_stack_core_defines.svh]
// Assertion macros used by the vote lockout stack datapath.
`ifndef VOTE_LOCKOUT_STACK_CORE_DEFINES_SVH
`define VOTE_LOCKOUT_STACK_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define VLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define VLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vls_pkg.sv]
// Shared constants, types and controller/datapath interface for the vote lockout stack.
package vls_pkg;

    localparam int STACK_DEPTH = 31;
    localparam int SLOT_W      = 64;
    localparam int CONF_W      = 6;
    localparam int KEPT_W      = 5;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W     = SLOT_W + CONF_W;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 72;
    localparam int M_TUSER_W   = 2;

    localparam logic [CONF_W-1:0] CONF_ONE = CONF_W'(1);

    localparam logic MODE_VOTE     = 1'b0;
    localparam logic MODE_SIMULATE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_TOP,
        ST_CHECK_TOP,
        ST_EVAL_EXP,
        ST_READ_EXP,
        ST_COMMIT,
        ST_READ_ROOT,
        ST_POP_ROOT,
        ST_READ_INC,
        ST_EVAL_INC,
        ST_PUSH,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch the incoming word, start the walk at the top
        logic rd_en;      // read one stack entry
        logic rd_bottom;  // read the bottom entry instead of the walk position
        logic flag_err;   // vote below top slot
        logic dec;        // drop the walk position by one (expired vote)
        logic commit;     // stack count takes the walk position (vote mode only)
        logic pop_root;   // remove the bottom entry as the new root
        logic incr;       // bump confirmations of the entry just read
        logic push;       // write the new vote on top
        logic out_load;   // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mode;
        logic empty;
        logic below_top;
        logic expired;
        logic conf_match;
        logic idx_zero;
        logic idx_one;
        logic idx_full;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/vls_dp.sv]
// Datapath: vote stack memory, walk pointer, lockout compare and result registers.
`include "vote_lockout_stack_core_defines.svh"

module vls_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vls_pkg::t_dp_cmd              i_cmd,
    output vls_pkg::t_dp_stat             o_stat,
    input  logic                          i_mode,
    input  logic [vls_pkg::SLOT_W-1:0]    i_slot,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_root_valid,
    output logic [vls_pkg::SLOT_W-1:0]    o_root_slot,
    output logic [vls_pkg::KEPT_W-1:0]    o_kept_count,
    output logic                          o_order_error
);

    localparam int SUM_W = vls_pkg::COUNT_W + 1;

    logic [vls_pkg::ENTRY_W-1:0] mem [vls_pkg::STACK_DEPTH];

    logic                          r_mode;
    logic [vls_pkg::SLOT_W-1:0]    r_slot;
    logic [vls_pkg::COUNT_W-1:0]   r_idx;
    logic [vls_pkg::COUNT_W-1:0]   r_count;
    logic [vls_pkg::ADDR_W-1:0]    r_base;
    logic [vls_pkg::CONF_W-1:0]    r_expect;
    logic [vls_pkg::COUNT_W-1:0]   r_kept;
    logic                          r_err;
    logic                          r_root_valid;
    logic [vls_pkg::SLOT_W-1:0]    r_root_slot;
    logic [vls_pkg::ENTRY_W-1:0]   r_rd_q;

    logic                          r_out_valid;
    logic                          r_out_root_valid;
    logic [vls_pkg::SLOT_W-1:0]    r_out_root_slot;
    logic [vls_pkg::COUNT_W-1:0]   r_out_kept;
    logic                          r_out_err;

    logic [vls_pkg::SLOT_W-1:0]    rd_slot;
    logic [vls_pkg::CONF_W-1:0]    rd_conf;
    logic [vls_pkg::COUNT_W-1:0]   top_idx;
    logic [vls_pkg::ADDR_W-1:0]    rd_addr;
    logic [vls_pkg::ADDR_W-1:0]    wr_addr;
    logic [vls_pkg::ENTRY_W-1:0]   wr_data;
    logic                          wr_en;
    logic [vls_pkg::SLOT_W:0]      diff_sum;
    logic [vls_pkg::SLOT_W-1:0]    hi_mask;
    logic [vls_pkg::ADDR_W-1:0]    base_next;

    // Logical stack position (0 = bottom) to memory address in the ring.
    function automatic logic [vls_pkg::ADDR_W-1:0] phys_addr(
        input logic [vls_pkg::ADDR_W-1:0]  base,
        input logic [vls_pkg::COUNT_W-1:0] idx
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(idx);
        if (sum >= SUM_W'(vls_pkg::STACK_DEPTH)) begin
            sum = sum - SUM_W'(vls_pkg::STACK_DEPTH);
        end
        return sum[vls_pkg::ADDR_W-1:0];
    endfunction

    assign rd_slot = r_rd_q[vls_pkg::ENTRY_W-1:vls_pkg::CONF_W];
    assign rd_conf = r_rd_q[vls_pkg::CONF_W-1:0];
    assign top_idx = r_idx - vls_pkg::COUNT_W'(1);

    assign rd_addr = i_cmd.rd_bottom ? r_base : phys_addr(r_base, top_idx);

    assign base_next = (r_base == vls_pkg::ADDR_W'(vls_pkg::STACK_DEPTH - 1)) ?
                       '0 : r_base + vls_pkg::ADDR_W'(1);

    always_comb begin
        wr_en   = i_cmd.incr | i_cmd.push;
        wr_addr = phys_addr(r_base, top_idx);
        wr_data = {rd_slot, rd_conf + vls_pkg::CONF_W'(1)};
        if (i_cmd.push) begin
            wr_addr = phys_addr(r_base, r_count);
            wr_data = {r_slot, vls_pkg::CONF_ONE};
        end
    end

    // slot + ~entry = slot - entry - 1 with carry set exactly when slot > entry.
    // The vote has expired when that difference reaches 2^confirmations.
    assign diff_sum = {1'b0, r_slot} + {1'b0, ~rd_slot};
    assign hi_mask  = {vls_pkg::SLOT_W{1'b1}} << rd_conf;

    always_comb begin
        o_stat            = '0;
        o_stat.mode       = r_mode;
        o_stat.empty      = (r_count == '0);
        o_stat.below_top  = (r_slot < rd_slot);
        o_stat.expired    = diff_sum[vls_pkg::SLOT_W] &
                            (|(diff_sum[vls_pkg::SLOT_W-1:0] & hi_mask));
        o_stat.conf_match = (rd_conf == r_expect);
        o_stat.idx_zero   = (r_idx == '0);
        o_stat.idx_one    = (r_idx == vls_pkg::COUNT_W'(1));
        o_stat.idx_full   = (r_idx == vls_pkg::COUNT_W'(vls_pkg::STACK_DEPTH));
        o_stat.out_free   = ~r_out_valid | i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
            r_base  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= r_count;
            end else if (i_cmd.dec | i_cmd.pop_root | i_cmd.incr) begin
                r_idx <= top_idx;
            end
            if (i_cmd.commit & (r_mode == vls_pkg::MODE_VOTE)) begin
                r_count <= r_idx;
            end else if (i_cmd.pop_root) begin
                r_count <= r_count - vls_pkg::COUNT_W'(1);
            end else if (i_cmd.push) begin
                r_count <= r_count + vls_pkg::COUNT_W'(1);
            end
            if (i_cmd.pop_root) begin
                r_base <= base_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode       <= i_mode;
            r_slot       <= i_slot;
            r_err        <= 1'b0;
            r_root_valid <= 1'b0;
            r_root_slot  <= '0;
        end
        if (i_cmd.commit | i_cmd.flag_err) begin
            r_kept <= r_idx;
        end
        if (i_cmd.flag_err) begin
            r_err <= 1'b1;
        end
        if (i_cmd.commit) begin
            r_expect <= vls_pkg::CONF_ONE;
        end else if (i_cmd.incr) begin
            r_expect <= r_expect + vls_pkg::CONF_W'(1);
        end
        if (i_cmd.pop_root) begin
            r_root_valid <= 1'b1;
            r_root_slot  <= rd_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_root_valid <= r_root_valid;
            r_out_root_slot  <= r_root_slot;
            r_out_kept       <= r_kept;
            r_out_err        <= r_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_root_valid  = r_out_root_valid;
    assign o_root_slot   = r_out_root_slot;
    assign o_kept_count  = vls_pkg::KEPT_W'(r_out_kept);
    assign o_order_error = r_out_err;

    `VLS_ASSERT(a_count_bound, r_count <= vls_pkg::COUNT_W'(vls_pkg::STACK_DEPTH), "stack count exceeds depth")
    `VLS_ASSERT(a_base_bound, r_base <= vls_pkg::ADDR_W'(vls_pkg::STACK_DEPTH - 1), "ring base out of range")
    `VLS_ASSERT(a_pop_only_full, !i_cmd.pop_root || r_count == vls_pkg::COUNT_W'(vls_pkg::STACK_DEPTH), "root popped from a stack that is not full")
    `VLS_ASSERT_NEXT(a_push_grows, i_cmd.push, r_count == $past(r_count) + vls_pkg::COUNT_W'(1), "push did not grow the stack")

endmodule

[rtl/vls_ctrl.sv]
// Controller: sequences expiry walk, root pop, confirmation walk and push for one word.
module vls_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  vls_pkg::t_dp_stat    i_stat,
    output vls_pkg::t_dp_cmd     o_cmd
);

    vls_pkg::t_state r_state;
    vls_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vls_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == vls_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            vls_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_stat.empty ? vls_pkg::ST_COMMIT : vls_pkg::ST_READ_TOP;
                end
            end
            vls_pkg::ST_READ_TOP: begin
                o_cmd.rd_en = 1'b1;
                n_state = vls_pkg::ST_CHECK_TOP;
            end
            vls_pkg::ST_CHECK_TOP: begin
                if (i_stat.mode == vls_pkg::MODE_VOTE && i_stat.below_top) begin
                    o_cmd.flag_err = 1'b1;
                    n_state = vls_pkg::ST_OUT;
                end else begin
                    n_state = vls_pkg::ST_EVAL_EXP;
                end
            end
            vls_pkg::ST_EVAL_EXP: begin
                if (i_stat.expired) begin
                    o_cmd.dec = 1'b1;
                    n_state = i_stat.idx_one ? vls_pkg::ST_COMMIT : vls_pkg::ST_READ_EXP;
                end else begin
                    n_state = vls_pkg::ST_COMMIT;
                end
            end
            vls_pkg::ST_READ_EXP: begin
                o_cmd.rd_en = 1'b1;
                n_state = vls_pkg::ST_EVAL_EXP;
            end
            vls_pkg::ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                if (i_stat.mode == vls_pkg::MODE_SIMULATE) begin
                    n_state = vls_pkg::ST_OUT;
                end else if (i_stat.idx_full) begin
                    n_state = vls_pkg::ST_READ_ROOT;
                end else if (i_stat.idx_zero) begin
                    n_state = vls_pkg::ST_PUSH;
                end else begin
                    n_state = vls_pkg::ST_READ_INC;
                end
            end
            vls_pkg::ST_READ_ROOT: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_bottom = 1'b1;
                n_state = vls_pkg::ST_POP_ROOT;
            end
            vls_pkg::ST_POP_ROOT: begin
                // Depth is at least two, so entries remain to walk.
                o_cmd.pop_root = 1'b1;
                n_state = vls_pkg::ST_READ_INC;
            end
            vls_pkg::ST_READ_INC: begin
                o_cmd.rd_en = 1'b1;
                n_state = vls_pkg::ST_EVAL_INC;
            end
            vls_pkg::ST_EVAL_INC: begin
                if (i_stat.conf_match) begin
                    o_cmd.incr = 1'b1;
                    n_state = i_stat.idx_one ? vls_pkg::ST_PUSH : vls_pkg::ST_READ_INC;
                end else begin
                    n_state = vls_pkg::ST_PUSH;
                end
            end
            vls_pkg::ST_PUSH: begin
                o_cmd.push = 1'b1;
                n_state = vls_pkg::ST_OUT;
            end
            vls_pkg::ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = vls_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vls_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/vote_lockout_stack_core.sv]
// Top level of the vote lockout stack: stream ports around controller and datapath.
//
// The block keeps a stack of up to 31 votes, each a slot with a confirmation
// count, in a small ring memory with one read and one write port. Each input
// word yields exactly one output word. A vote word (tuser = 0) first drops
// votes from the top whose lockout (slot + 2^confirmations) ends before the
// new slot, then, if the stack is still full, removes the bottom vote and
// reports it as the new root, then bumps the confirmations of the run of top
// entries that read 1, 2, 3 and so on from the top, and finally pushes the new
// vote with one confirmation. A vote below the current top slot is rejected
// with order_error set and leaves the stack unchanged. A simulate word
// (tuser = 1) changes nothing and only reports how many votes would remain.
// The work is sequential, one word at a time, and every visit to a stack
// entry passes through a read state and an evaluate state because the memory
// read is registered; a root removal adds a read state and a pop state. The
// input is taken again as soon as a result sits in the output register, so a
// slow sink stalls the block only when a second result is ready before the
// first has been taken. No clearing pass is needed after reset: the stack
// starts empty and only written entries are ever read.
module vote_lockout_stack_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [vls_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // [63:0] vote_slot
    input  logic                              s_axis_tuser,   // [0] mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [vls_pkg::M_TDATA_W-1:0]     m_axis_tdata,   // [63:0] root_slot,
                                                               // [68:64] kept_count,
                                                               // [71:69] zero
    output logic [vls_pkg::M_TUSER_W-1:0]     m_axis_tuser    // [0] root_valid,
                                                               // [1] order_error
);

    vls_pkg::t_dp_cmd                 cmd;
    vls_pkg::t_dp_stat                stat;
    logic                             root_valid;
    logic [vls_pkg::SLOT_W-1:0]       root_slot;
    logic [vls_pkg::KEPT_W-1:0]       kept_count;
    logic                             order_error;

    // The controller takes a word only in its idle state, so accept equals load.
    vls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vls_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_mode        (s_axis_tuser),
        .i_slot        (s_axis_tdata[vls_pkg::SLOT_W-1:0]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_root_valid  (root_valid),
        .o_root_slot   (root_slot),
        .o_kept_count  (kept_count),
        .o_order_error (order_error)
    );

    // Result fields packed from the lowest bit up, padded to whole bytes.
    assign m_axis_tdata = {{(vls_pkg::M_TDATA_W - vls_pkg::SLOT_W - vls_pkg::KEPT_W){1'b0}},
                           kept_count, root_slot};
    assign m_axis_tuser = {order_error, root_valid};

endmodule
